FILE: rtl/layout_cache_blob_validator_top_assert.svh
// Assertion macros for the layout cache blob validator.
// Used by layout_cache_blob_validator_top; expects clk and rst in scope.
`ifndef LAYOUT_CACHE_BLOB_VALIDATOR_TOP_ASSERT_SVH
`define LAYOUT_CACHE_BLOB_VALIDATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define LCBV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcbv assertion failed");
// Next-cycle implication
`define LCBV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcbv assertion failed");
`else
`define LCBV_ASSERT_IMP(lbl, ante, cons)
`define LCBV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/lcbv_pkg.sv
// Shared types and constants for the layout cache blob validator.
// No dependencies; imported by every module of the block.
package lcbv_pkg;

  // Format limits and constants
  localparam int unsigned MAX_GLYPHS   = 4096;
  localparam int unsigned MAX_PAGES    = 256;
  localparam logic [31:0] BLOB_MAGIC   = 32'd1379419715;
  localparam logic [15:0] BLOB_VERSION = 16'd1;

  localparam logic [31:0] FNV_BASIS    = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME    = 32'h01000193;
  localparam int unsigned CKSUM_OFFSET = 48;
  localparam int unsigned HDR_BYTES    = 52;
  localparam int unsigned GLYPH_REC_SZ = 20;
  localparam int unsigned PAGE_REC_SZ  = 8;

  // Byte counter, saturating
  localparam int unsigned POS_W = 24;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Widths of in-bound counts and of the size they imply
  localparam int unsigned GCNT_W = $clog2(MAX_GLYPHS + 1);
  localparam int unsigned PCNT_W = $clog2(MAX_PAGES + 1);
  localparam int unsigned NEED_W =
    $clog2(HDR_BYTES + GLYPH_REC_SZ * MAX_GLYPHS + PAGE_REC_SZ * MAX_PAGES + 1);
  localparam int unsigned CMP_W  = (NEED_W > POS_W) ? NEED_W : POS_W;

  // Result field widths
  localparam int unsigned GREC_W = 13;
  localparam int unsigned PREC_W = 9;
  localparam int unsigned REQ_W  = 17;

  // Header word slots (byte offset / 4)
  typedef enum logic [3:0] {
    W_MAGIC        = 4'd0,
    W_VERSION      = 4'd1,
    W_VIEWPORT     = 4'd2,
    W_FONT_PX      = 4'd3,
    W_BODY_INK     = 4'd4,
    W_LINK_INK     = 4'd5,
    W_FONT_SZ      = 4'd6,
    W_FONT_SUM     = 4'd7,
    W_TEXT_SZ      = 4'd8,
    W_TEXT_SUM     = 4'd9,
    W_GLYPHS       = 4'd10,
    W_PAGES        = 4'd11,
    W_CKSUM        = 4'(CKSUM_OFFSET / 4)
  } hdr_word_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    R_VIEWPORT     = 3'd0,
    R_FONT_PX      = 3'd1,
    R_BODY_INK     = 3'd2,
    R_LINK_INK     = 3'd3,
    R_FONT_SZ      = 3'd4,
    R_FONT_SUM     = 3'd5,
    R_TEXT_SZ      = 3'd6,
    R_TEXT_SUM     = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_BAD_CKSUM = 3'd4
  } status_t;

  // Expected layout key
  typedef struct packed {
    logic [31:0] viewport;
    logic [15:0] font_px;
    logic [31:0] body_ink;
    logic [31:0] link_ink;
    logic [31:0] font_sz;
    logic [31:0] font_sum;
    logic [31:0] text_sz;
    logic [31:0] text_sum;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0] blob_byte;
    logic       last_byte;
  } blob_in_t;

  typedef struct packed {
    status_t            status;
    logic [GREC_W-1:0]  glyph_records;
    logic [PREC_W-1:0]  page_records;
    logic [REQ_W-1:0]   required_bytes;
  } result_t;

  // Snapshot of a finished blob, handed from parser to verdict stage
  typedef struct packed {
    logic [POS_W-1:0]   len;
    logic               magic_bad;
    logic               version_bad;
    logic               key_bad;
    logic               in_bound;
    logic [NEED_W-1:0]  need;
    logic [GCNT_W-1:0]  glyphs;
    logic [PCNT_W-1:0]  pages;
    logic [31:0]        cksum;
    logic [31:0]        hash;
  } fin_t;

endpackage

FILE: rtl/lcbv_parse.sv
// Header parser and body hash for the blob validator: one byte per cycle while accept is high.
// Depends on lcbv_pkg; hands a snapshot of each finished blob to lcbv_verdict.
module lcbv_parse
  import lcbv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  blob_in_t  item,
  input  cfg_regs_t cfg,
  input  logic      fin_take,
  output logic      fin_valid,
  output fin_t      fin
);

  logic [POS_W-1:0]  pos, pos_next;
  logic [23:0]       word, word_next;
  logic              magic_bad, magic_bad_next;
  logic              version_bad, version_bad_next;
  logic              key_bad, key_bad_next;
  logic [31:0]       glyph_total, glyph_total_next;
  logic [31:0]       page_total, page_total_next;
  logic [31:0]       cksum, cksum_next;
  logic [31:0]       hash, hash_next;
  logic [NEED_W-1:0] need;
  logic              in_bound;

  logic              in_hdr;
  logic [1:0]        lane;
  logic [31:0]       word_full;
  logic              hash_en;
  logic [31:0]       hash_mix;
  fin_t              snap;

  // Size implied by the counts; settles long before the body starts
  always_ff @(posedge clk) begin
    if (rst) begin
      need     <= '0;
      in_bound <= 1'b1;
    end else begin
      need     <= NEED_W'(HDR_BYTES)
                + NEED_W'(glyph_total[GCNT_W-1:0]) * NEED_W'(GLYPH_REC_SZ)
                + NEED_W'(page_total[PCNT_W-1:0]) * NEED_W'(PAGE_REC_SZ);
      in_bound <= (glyph_total <= 32'(MAX_GLYPHS)) && (page_total <= 32'(MAX_PAGES));
    end
  end

  // Per-byte update of header fields and body hash
  always_comb begin
    in_hdr    = pos < POS_W'(HDR_BYTES);
    lane      = pos[1:0];
    word_full = {item.blob_byte, word};
    hash_mix  = hash ^ {24'd0, item.blob_byte};
    hash_en   = !in_hdr && in_bound && (CMP_W'(pos) < CMP_W'(need));

    word_next        = word;
    magic_bad_next   = magic_bad;
    version_bad_next = version_bad;
    key_bad_next     = key_bad;
    glyph_total_next = glyph_total;
    page_total_next  = page_total;
    cksum_next       = cksum;
    hash_next        = hash;

    if (in_hdr) begin
      unique case (lane)
        2'd0: word_next = {16'd0, item.blob_byte};
        2'd1: word_next = {8'd0, item.blob_byte, word[7:0]};
        2'd2: word_next = {item.blob_byte, word[15:0]};
        default: word_next = word;
      endcase
      if (lane == 2'd3) begin
        unique case (hdr_word_t'(pos[5:2]))
          W_MAGIC:        magic_bad_next   = word_full != BLOB_MAGIC;
          W_VERSION:      version_bad_next = word_full[15:0] != BLOB_VERSION;
          W_VIEWPORT:     key_bad_next = key_bad | (word_full != cfg.viewport);
          W_FONT_PX:      key_bad_next = key_bad | (word_full[15:0] != cfg.font_px);
          W_BODY_INK:     key_bad_next = key_bad | (word_full != cfg.body_ink);
          W_LINK_INK:     key_bad_next = key_bad | (word_full != cfg.link_ink);
          W_FONT_SZ:      key_bad_next = key_bad | (word_full != cfg.font_sz);
          W_FONT_SUM:     key_bad_next = key_bad | (word_full != cfg.font_sum);
          W_TEXT_SZ:      key_bad_next = key_bad | (word_full != cfg.text_sz);
          W_TEXT_SUM:     key_bad_next = key_bad | (word_full != cfg.text_sum);
          W_GLYPHS:       glyph_total_next = word_full;
          W_PAGES:        page_total_next  = word_full;
          W_CKSUM:        cksum_next       = word_full;
          default:        cksum_next       = cksum;
        endcase
      end
    end else if (hash_en) begin
      hash_next = hash_mix * FNV_PRIME;
    end

    pos_next = (pos != POS_MAX) ? pos + POS_W'(1) : pos;

    snap.len         = pos_next;
    snap.magic_bad   = magic_bad_next;
    snap.version_bad = version_bad_next;
    snap.key_bad     = key_bad_next;
    snap.in_bound    = in_bound;
    snap.need        = need;
    snap.glyphs      = glyph_total[GCNT_W-1:0];
    snap.pages       = page_total[PCNT_W-1:0];
    snap.cksum       = cksum_next;
    snap.hash        = hash_next;
  end

  // Blob state; cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst || (accept && item.last_byte)) begin
      pos         <= '0;
      word        <= '0;
      magic_bad   <= 1'b0;
      version_bad <= 1'b0;
      key_bad     <= 1'b0;
      glyph_total <= '0;
      page_total  <= '0;
      cksum       <= '0;
      hash        <= FNV_BASIS;
    end else if (accept) begin
      pos         <= pos_next;
      word        <= word_next;
      magic_bad   <= magic_bad_next;
      version_bad <= version_bad_next;
      key_bad     <= key_bad_next;
      glyph_total <= glyph_total_next;
      page_total  <= page_total_next;
      cksum       <= cksum_next;
      hash        <= hash_next;
    end
  end

  // Snapshot register for the verdict stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (accept && item.last_byte) begin
      fin_valid <= 1'b1;
    end else if (fin_take) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.last_byte) begin
      fin <= snap;
    end
  end

endmodule

FILE: rtl/lcbv_verdict.sv
// Verdict stage: turns a finished-blob snapshot into a status and counts.
// Depends on lcbv_pkg; fed by lcbv_parse, drives the result register.
module lcbv_verdict
  import lcbv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fin_valid,
  input  fin_t    fin,
  input  logic    result_stall,
  output logic    fin_take,
  output logic    result_valid,
  output result_t result
);

  status_t status;
  result_t result_next;

  assign fin_take = fin_valid && (!result_valid || !result_stall);

  // Checks in the order the file format defines them
  always_comb begin
    priority if (fin.len < POS_W'(HDR_BYTES))           status = ST_BAD_SIZE;
    else if (fin.magic_bad)                             status = ST_BAD_MAGIC;
    else if (fin.version_bad)                           status = ST_MISMATCH;
    else if (!fin.in_bound)                             status = ST_BAD_SIZE;
    else if (CMP_W'(fin.len) < CMP_W'(fin.need))        status = ST_BAD_SIZE;
    else if (fin.key_bad)                               status = ST_MISMATCH;
    else if (fin.hash != fin.cksum)                     status = ST_BAD_CKSUM;
    else                                                status = ST_OK;

    result_next.status = status;
    if (status == ST_OK) begin
      result_next.glyph_records  = GREC_W'(fin.glyphs);
      result_next.page_records   = PREC_W'(fin.pages);
      result_next.required_bytes = REQ_W'(fin.need);
    end else begin
      result_next.glyph_records  = '0;
      result_next.page_records   = '0;
      result_next.required_bytes = '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      result <= result_next;
    end
  end

endmodule

FILE: rtl/layout_cache_blob_validator_top.sv
// Layout cache blob validator, top level: config registers and stage wiring.
// Depends on lcbv_pkg, lcbv_parse, lcbv_verdict and the assertion header.
//
// Streams a layout cache blob in one byte per item, one item per clock while
// blob_stall is low, and gives one result item per blob after the byte marked
// last. The 52-byte header is checked against the magic, version and the
// expected layout key held in the configuration registers; the body is hashed
// with 32-bit FNV-1a (one constant multiply per byte) up to the size the header
// implies and compared with the stored checksum. The edge that takes the last
// byte snapshots the blob state; the verdict is then registered into the result
// register once that register is empty or not stalled. Bytes are taken in every
// cycle in which blob_stall is low; blob_stall rises only when a finished blob
// is still waiting behind a stalled result. Write the configuration registers
// only between blobs; cfg_ready is always high.
`include "layout_cache_blob_validator_top_assert.svh"

module layout_cache_blob_validator_top
  import lcbv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        blob_valid,
  output logic        blob_stall,
  input  blob_in_t    blob,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_reg_t    cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_regs_t cfg;
  logic      accept;
  logic      fin_valid;
  logic      fin_take;
  fin_t      fin;

  assign cfg_ready  = 1'b1;
  assign blob_stall = fin_valid && !fin_take;
  assign accept     = blob_valid && !blob_stall;

  // Expected layout key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        R_VIEWPORT:     cfg.viewport     <= cfg_data;
        R_FONT_PX:      cfg.font_px      <= cfg_data[15:0];
        R_BODY_INK:     cfg.body_ink     <= cfg_data;
        R_LINK_INK:     cfg.link_ink     <= cfg_data;
        R_FONT_SZ:      cfg.font_sz      <= cfg_data;
        R_FONT_SUM:     cfg.font_sum     <= cfg_data;
        R_TEXT_SZ:      cfg.text_sz      <= cfg_data;
        R_TEXT_SUM:     cfg.text_sum     <= cfg_data;
        default:        cfg.viewport     <= cfg.viewport;
      endcase
    end
  end

  lcbv_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (blob),
    .cfg       (cfg),
    .fin_take  (fin_take),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  lcbv_verdict u_verdict (
    .clk          (clk),
    .rst          (rst),
    .fin_valid    (fin_valid),
    .fin          (fin),
    .result_stall (result_stall),
    .fin_take     (fin_take),
    .result_valid (result_valid),
    .result       (result)
  );

  // Input only backs up behind a finished blob that cannot move on
  `LCBV_ASSERT_IMP(a_stall_needs_fin, blob_stall, fin_valid && result_valid && result_stall)
  // A taken last byte always leaves a snapshot for the verdict stage
  `LCBV_ASSERT_NEXT(a_last_makes_fin, accept && blob.last_byte, fin_valid)
  // Failed blobs report no counts
  `LCBV_ASSERT_IMP(a_fail_zero, result_valid && (result.status != ST_OK), (result.glyph_records == '0) && (result.page_records == '0) && (result.required_bytes == '0))
  // A good blob always covers at least the header
  `LCBV_ASSERT_IMP(a_ok_size, result_valid && (result.status == ST_OK), result.required_bytes >= REQ_W'(HDR_BYTES))

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for layout_cache_blob_validator_top: streams generated cache blobs
// byte by byte; checks every verdict against a pinned one or an in-bench header parser.
// Depends on lcbv_pkg and the block's RTL; reads no files.
module tb_top;
  import lcbv_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned RAND_ITEMS    = 400;
  localparam int unsigned MIN_RAND_BLOBS = 44;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned SETTLE_CYCLES = 4;

  // Defects a generated blob can carry, OR-ed together
  typedef logic [4:0] flaw_t;
  localparam flaw_t FL_NONE  = 5'b00000;
  localparam flaw_t FL_MAGIC = 5'b00001;
  localparam flaw_t FL_VER   = 5'b00010;
  localparam flaw_t FL_KEY   = 5'b00100;
  localparam flaw_t FL_SUM   = 5'b01000;
  localparam flaw_t FL_NOISE = 5'b10000;

  // One blob to build: counts, bytes cut from the end, trailing bytes
  // (or the whole length for a noise blob), and an optional pinned verdict
  typedef struct {
    flaw_t       flaw;
    logic [31:0] glyphs;
    logic [31:0] pages;
    int unsigned cut;
    int unsigned trail;
    bit          pinned;
    result_t     want;
  } blob_case_t;

  typedef struct packed {
    logic    on;
    result_t want;
  } pin_t;

  logic        clk;
  logic        rst;
  logic        blob_valid;
  logic        blob_stall;
  blob_in_t    blob;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_t    cfg_index;
  logic [31:0] cfg_data;

  layout_cache_blob_validator_top dut (.*);

  // Byte stream, pinned verdicts and expected verdicts
  blob_in_t    feed_q[$];
  pin_t        pin_q[$];
  result_t     verdict_q[$];
  int unsigned blobs_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  bit          hold_req     = 0;

  // Layout key as last written to the block
  cfg_regs_t   key_cfg;

  // Parser model state
  logic [POS_W-1:0] byte_pos;
  logic [31:0]      word_acc;
  bit               magic_err;
  bit               ver_err;
  bit               key_err;
  logic [31:0]      glyph_cnt;
  logic [31:0]      page_cnt;
  logic [31:0]      cksum_word;
  logic [31:0]      body_fnv;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("layout_cache_blob_validator_top test failed");
    $finish;
  end

  task automatic flag(input string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endtask

  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

  function automatic bit counts_ok();
    return glyph_cnt <= MAX_GLYPHS && page_cnt <= MAX_PAGES;
  endfunction

  function automatic logic [63:0] size_needed();
    return 64'(HDR_BYTES) + 64'(glyph_cnt) * 64'(GLYPH_REC_SZ)
         + 64'(page_cnt) * 64'(PAGE_REC_SZ);
  endfunction

  function automatic void clear_parse();
    byte_pos   = '0;
    word_acc   = '0;
    magic_err  = 1'b0;
    ver_err    = 1'b0;
    key_err    = 1'b0;
    glyph_cnt  = '0;
    page_cnt   = '0;
    cksum_word = '0;
    body_fnv   = FNV_BASIS;
  endfunction

  // A complete header word has been assembled
  function automatic void take_word(input hdr_word_t slot, input logic [31:0] w);
    case (slot)
      W_MAGIC:        magic_err = (w != BLOB_MAGIC);
      W_VERSION:      ver_err = (w[15:0] != BLOB_VERSION);
      W_VIEWPORT:     if (w != key_cfg.viewport) key_err = 1'b1;
      W_FONT_PX:      if (w[15:0] != key_cfg.font_px) key_err = 1'b1;
      W_BODY_INK:     if (w != key_cfg.body_ink) key_err = 1'b1;
      W_LINK_INK:     if (w != key_cfg.link_ink) key_err = 1'b1;
      W_FONT_SZ:      if (w != key_cfg.font_sz) key_err = 1'b1;
      W_FONT_SUM:     if (w != key_cfg.font_sum) key_err = 1'b1;
      W_TEXT_SZ:      if (w != key_cfg.text_sz) key_err = 1'b1;
      W_TEXT_SUM:     if (w != key_cfg.text_sum) key_err = 1'b1;
      W_GLYPHS:       glyph_cnt = w;
      W_PAGES:        page_cnt = w;
      W_CKSUM:        cksum_word = w;
      default: ;
    endcase
  endfunction

  // Parse one accepted byte; on the last byte queue the verdict
  function automatic void absorb_byte(input blob_in_t it);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] len;
    logic [63:0]      need;
    logic [1:0]       lane;
    result_t          r;
    pin_t             pin;
    p = byte_pos;
    if (p < HDR_BYTES) begin
      lane = p[1:0];
      if (lane == 2'd0) word_acc = {24'd0, it.blob_byte};
      else word_acc = word_acc | ({24'd0, it.blob_byte} << (8 * lane));
      if (lane == 2'd3) take_word(hdr_word_t'(p[5:2]), word_acc);
    end else if (counts_ok() && 64'(p) < size_needed()) begin
      body_fnv = fnv_mix(body_fnv, it.blob_byte);
    end
    len = (p < POS_MAX) ? p + 1'b1 : POS_MAX;
    byte_pos = len;
    if (!it.last_byte) return;

    // Checks in the order the file format defines
    need = size_needed();
    r = '0;
    if (len < HDR_BYTES) r.status = ST_BAD_SIZE;
    else if (magic_err) r.status = ST_BAD_MAGIC;
    else if (ver_err) r.status = ST_MISMATCH;
    else if (!counts_ok()) r.status = ST_BAD_SIZE;
    else if (64'(len) < need) r.status = ST_BAD_SIZE;
    else if (key_err) r.status = ST_MISMATCH;
    else if (body_fnv != cksum_word) r.status = ST_BAD_CKSUM;
    else r.status = ST_OK;
    if (r.status == ST_OK) begin
      r.glyph_records  = glyph_cnt[GREC_W-1:0];
      r.page_records   = page_cnt[PREC_W-1:0];
      r.required_bytes = need[REQ_W-1:0];
    end
    pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
    verdict_q.push_back(pin.on ? pin.want : r);
    clear_parse();
  endfunction

  function automatic blob_case_t blob_case(input flaw_t f, input logic [31:0] g,
                                           input logic [31:0] p, input int unsigned cut,
                                           input int unsigned trail, input bit pinned,
                                           input status_t st, input int unsigned gr,
                                           input int unsigned pr, input int unsigned rq);
    blob_case_t c;
    c.flaw   = f;
    c.glyphs = g;
    c.pages  = p;
    c.cut    = cut;
    c.trail  = trail;
    c.pinned = pinned;
    c.want.status         = st;
    c.want.glyph_records  = GREC_W'(gr);
    c.want.page_records   = PREC_W'(pr);
    c.want.required_bytes = REQ_W'(rq);
    return c;
  endfunction

  // Build the bytes of one blob against the current key and queue them
  function automatic int unsigned queue_blob(input blob_case_t c);
    logic [31:0] hw [13];
    logic [7:0]  body [$];
    logic [7:0]  blob_bytes [$];
    logic [31:0] h;
    int unsigned n;
    int unsigned slot;
    int unsigned cut;
    blob_in_t    it;
    pin_t        pin;
    if (c.flaw & FL_NOISE) begin
      n = (c.trail == 0) ? 1 : c.trail;
      repeat (n) blob_bytes.push_back(8'($urandom));
    end else begin
      // Reserved half-words get random content; they are never checked
      hw[W_MAGIC]        = BLOB_MAGIC;
      hw[W_VERSION]      = {16'($urandom), BLOB_VERSION};
      hw[W_VIEWPORT]     = key_cfg.viewport;
      hw[W_FONT_PX]      = {16'($urandom), key_cfg.font_px};
      hw[W_BODY_INK]     = key_cfg.body_ink;
      hw[W_LINK_INK]     = key_cfg.link_ink;
      hw[W_FONT_SZ]      = key_cfg.font_sz;
      hw[W_FONT_SUM]     = key_cfg.font_sum;
      hw[W_TEXT_SZ]      = key_cfg.text_sz;
      hw[W_TEXT_SUM]     = key_cfg.text_sum;
      hw[W_GLYPHS]       = c.glyphs;
      hw[W_PAGES]        = c.pages;
      if (c.flaw & FL_MAGIC) hw[W_MAGIC] ^= 32'd1 << $urandom_range(0, 31);
      if (c.flaw & FL_VER) hw[W_VERSION] ^= 32'd1 << $urandom_range(0, 15);
      if (c.flaw & FL_KEY) begin
        slot = $urandom_range(W_VIEWPORT, W_TEXT_SUM);
        hw[slot] ^= 32'd1 << ((slot == W_FONT_PX) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 31));
      end
      if (c.glyphs <= MAX_GLYPHS && c.pages <= MAX_PAGES)
        n = GLYPH_REC_SZ * c.glyphs + PAGE_REC_SZ * c.pages;
      else
        n = $urandom_range(0, 40);
      h = FNV_BASIS;
      repeat (n) begin
        body.push_back(8'($urandom));
        h = fnv_mix(h, body[$]);
      end
      hw[W_CKSUM] = h;
      if (c.flaw & FL_SUM) hw[W_CKSUM] ^= 32'd1 << $urandom_range(0, 31);
      foreach (hw[i])
        for (int k = 0; k < 4; k++) blob_bytes.push_back(hw[i][8*k +: 8]);
      blob_bytes = {blob_bytes, body};
      cut = (c.cut >= blob_bytes.size()) ? blob_bytes.size() - 1 : c.cut;
      repeat (cut) void'(blob_bytes.pop_back());
      repeat (c.trail) blob_bytes.push_back(8'($urandom));
    end
    pin.on   = c.pinned;
    pin.want = c.want;
    pin_q.push_back(pin);
    foreach (blob_bytes[i]) begin
      it.blob_byte = blob_bytes[i];
      it.last_byte = (i == blob_bytes.size() - 1);
      feed_q.push_back(it);
    end
    blobs_queued++;
    return blob_bytes.size();
  endfunction

  // Mostly well-formed blobs with random content, the rest broken or noise
  function automatic blob_case_t rand_case();
    blob_case_t  c;
    int unsigned pick;
    c = blob_case(FL_NONE, $urandom_range(0, 3), $urandom_range(0, 3), 0, 0, 1'b0,
                  ST_OK, 0, 0, 0);
    if ($urandom_range(0, 9) == 0) begin
      c.glyphs = $urandom_range(0, 24);
      c.pages  = $urandom_range(0, 24);
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      c.flaw = FL_NONE;
    end else if (pick < 62) begin
      c.flaw = FL_MAGIC;
    end else if (pick < 68) begin
      c.flaw = FL_VER;
    end else if (pick < 76) begin
      c.flaw = FL_KEY;
    end else if (pick < 84) begin
      c.flaw = FL_SUM;
    end else if (pick < 90) begin
      if ($urandom_range(0, 1) == 0)
        c.glyphs = $urandom_range(0, 1) ? $urandom
                                         : $urandom_range(MAX_GLYPHS + 1, MAX_GLYPHS + 64);
      else
        c.pages = $urandom_range(0, 1) ? $urandom
                                        : $urandom_range(MAX_PAGES + 1, MAX_PAGES + 64);
    end else begin
      c.flaw  = FL_NOISE;
      c.trail = $urandom_range(1, 80);
    end
    if (c.flaw != FL_NOISE) begin
      if ($urandom_range(0, 4) == 0) c.trail = $urandom_range(1, 12);
      if ($urandom_range(0, 9) == 0) c.cut = $urandom_range(1, 60);
      if ($urandom_range(0, 19) == 0) c.flaw |= FL_KEY;
    end
    return c;
  endfunction

  function automatic logic [31:0] key_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Write all eight key registers back to back; caller sits on a clock edge
  task automatic load_key(input cfg_regs_t k);
    cfg_reg_t    r;
    logic [31:0] d;
    r = r.first();
    forever begin
      case (r)
        R_VIEWPORT:     d = k.viewport;
        R_FONT_PX:      d = {16'($urandom), k.font_px};
        R_BODY_INK:     d = k.body_ink;
        R_LINK_INK:     d = k.link_ink;
        R_FONT_SZ:      d = k.font_sz;
        R_FONT_SUM:     d = k.font_sum;
        R_TEXT_SZ:      d = k.text_sz;
        R_TEXT_SUM:     d = k.text_sum;
        default:        d = '0;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= d;
      do @(posedge clk); while (!cfg_ready);
      case (r)
        R_VIEWPORT:     key_cfg.viewport = d;
        R_FONT_PX:      key_cfg.font_px = d[15:0];
        R_BODY_INK:     key_cfg.body_ink = d;
        R_LINK_INK:     key_cfg.link_ink = d;
        R_FONT_SZ:      key_cfg.font_sz = d;
        R_FONT_SUM:     key_cfg.font_sum = d;
        R_TEXT_SZ:      key_cfg.text_sz = d;
        R_TEXT_SUM:     key_cfg.text_sum = d;
        default: ;
      endcase
      if (r == r.last()) break;
      r = r.next();
    end
    cfg_valid <= 1'b0;
  endtask

  // Every queued blob has produced its verdict, then let the pipe drain
  task automatic wait_idle();
    while (results_seen < blobs_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Byte sender: bursts and gaps; a stalled item is held unchanged
  initial begin : byte_sender
    int unsigned burst_left;
    int unsigned gap_left;
    burst_left = 0;
    gap_left   = 0;
    blob_valid <= 1'b0;
    blob       <= '0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (blob_valid && !blob_stall) begin
          absorb_byte(blob);
          void'(feed_q.pop_front());
        end
        if (!(blob_valid && blob_stall)) begin
          if (gap_left > 0) begin
            gap_left--;
            blob_valid <= 1'b0;
          end else if (feed_q.size() == 0) begin
            blob_valid <= 1'b0;
          end else begin
            blob_valid <= 1'b1;
            blob       <= feed_q[0];
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                       : $urandom_range(1, 40);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
        end
      end
    end
  end

  // Result receiver: epochs of differing stall density, plus one long hold
  initial begin : result_taker
    int unsigned epoch_left;
    int unsigned stall_pct;
    int unsigned hold_left;
    epoch_left = 0;
    stall_pct  = 0;
    hold_left  = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        if (epoch_left == 0) begin
          epoch_left = $urandom_range(50, 300);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        epoch_left--;
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : verdict_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        flag($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = verdict_q.pop_front();
        if (result.status !== want.status)
          flag($sformatf("result %0d status %0d, expected %0d", results_seen,
                         result.status, want.status));
        if (result.glyph_records !== want.glyph_records)
          flag($sformatf("result %0d glyph_records %0d, expected %0d", results_seen,
                         result.glyph_records, want.glyph_records));
        if (result.page_records !== want.page_records)
          flag($sformatf("result %0d page_records %0d, expected %0d", results_seen,
                         result.page_records, want.page_records));
        if (result.required_bytes !== want.required_bytes)
          flag($sformatf("result %0d required_bytes %0d, expected %0d", results_seen,
                         result.required_bytes, want.required_bytes));
      end
    end
  end

  initial begin : stimulus
    blob_case_t  steps [$];
    cfg_regs_t   k;
    int unsigned rand_items;
    int unsigned rand_base;
    int unsigned phase_items;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= R_VIEWPORT;
    cfg_data  <= '0;
    key_cfg = '0;
    clear_parse();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed blobs against an all-zero key
    load_key('0);
    steps.push_back(blob_case(FL_NOISE, 0, 0, 0, 1, 1, ST_BAD_SIZE, 0, 0, 0));
    steps.push_back(blob_case(FL_NONE, 0, 0, 1, 0, 1, ST_BAD_SIZE, 0, 0, 0));
    steps.push_back(blob_case(FL_NONE, 0, 0, 0, 0, 1, ST_OK, 0, 0, 52));
    steps.push_back(blob_case(FL_NONE, 1, 1, 0, 0, 1, ST_OK, 1, 1, 80));
    steps.push_back(blob_case(FL_NONE, 0, 0, 0, 20, 1, ST_OK, 0, 0, 52));
    steps.push_back(blob_case(FL_MAGIC, 0, 0, 0, 0, 1, ST_BAD_MAGIC, 0, 0, 0));
    steps.push_back(blob_case(FL_MAGIC | FL_VER | FL_KEY, 1, 0, 0, 0, 1,
                              ST_BAD_MAGIC, 0, 0, 0));
    steps.push_back(blob_case(FL_VER, 1, 0, 0, 0, 1, ST_MISMATCH, 0, 0, 0));
    steps.push_back(blob_case(FL_KEY, 1, 2, 0, 0, 1, ST_MISMATCH, 0, 0, 0));
    steps.push_back(blob_case(FL_SUM, 2, 3, 0, 0, 1, ST_BAD_CKSUM, 0, 0, 0));
    steps.push_back(blob_case(FL_NONE, MAX_GLYPHS + 1, 0, 0, 0, 1, ST_BAD_SIZE, 0, 0, 0));
    steps.push_back(blob_case(FL_NONE, 0, MAX_PAGES + 1, 0, 0, 1, ST_BAD_SIZE, 0, 0, 0));
    steps.push_back(blob_case(FL_KEY | FL_SUM, '1, '1, 0, 0, 1, ST_BAD_SIZE, 0, 0, 0));
    steps.push_back(blob_case(FL_NONE, 3, 2, 1, 0, 1, ST_BAD_SIZE, 0, 0, 0));
    steps.push_back(blob_case(FL_KEY, 3, 2, 5, 0, 1, ST_BAD_SIZE, 0, 0, 0));
    steps.push_back(blob_case(FL_KEY | FL_SUM, 1, 0, 0, 0, 1, ST_MISMATCH, 0, 0, 0));
    steps.push_back(blob_case(FL_VER, 5000, 0, 0, 0, 1, ST_MISMATCH, 0, 0, 0));
    steps.push_back(blob_case(FL_NONE, 2, 1, 0, 9, 1, ST_OK, 2, 1, 100));
    // Largest in-bound counts, cut down to the bare header
    steps.push_back(blob_case(FL_NONE, MAX_GLYPHS, MAX_PAGES, 83968, 0, 1,
                              ST_BAD_SIZE, 0, 0, 0));
    steps.push_back(blob_case(FL_NOISE, 0, 0, 0, 30, 1, ST_BAD_SIZE, 0, 0, 0));
    steps.push_back(blob_case(FL_NOISE, 0, 0, 0, 64, 0, ST_OK, 0, 0, 0));
    steps.push_back(blob_case(FL_NONE, 1, 2, 0, 3, 0, ST_OK, 0, 0, 0));
    foreach (steps[i]) void'(queue_blob(steps[i]));
    wait_idle();

    // More directed blobs against an all-ones key
    load_key('1);
    steps.delete();
    steps.push_back(blob_case(FL_NONE, 0, 0, 0, 0, 1, ST_OK, 0, 0, 52));
    steps.push_back(blob_case(FL_KEY, 0, 0, 0, 0, 1, ST_MISMATCH, 0, 0, 0));
    steps.push_back(blob_case(FL_KEY | FL_SUM, 2, 0, 0, 0, 1, ST_MISMATCH, 0, 0, 0));
    steps.push_back(blob_case(FL_NONE, 1, 0, 0, 30, 1, ST_OK, 1, 0, 72));
    steps.push_back(blob_case(FL_NONE, 2, 3, 0, 0, 0, ST_OK, 0, 0, 0));
    foreach (steps[i]) void'(queue_blob(steps[i]));
    wait_idle();

    // Random phases, each under a fresh key
    rand_items = 0;
    rand_base  = blobs_queued;
    while (rand_items < RAND_ITEMS || blobs_queued - rand_base < MIN_RAND_BLOBS) begin
      k.viewport     = key_word();
      k.font_px      = 16'(key_word());
      k.body_ink     = key_word();
      k.link_ink     = key_word();
      k.font_sz      = key_word();
      k.font_sum     = key_word();
      k.text_sz      = key_word();
      k.text_sum     = key_word();
      load_key(k);
      // First phase: hold results off while short blobs pile up behind them
      if (rand_items == 0) begin
        hold_req = 1'b1;
        repeat (40)
          rand_items += queue_blob(blob_case(FL_NOISE, 0, 0, 0, $urandom_range(1, 3), 0,
                                             ST_OK, 0, 0, 0));
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) phase_items += queue_blob(rand_case());
      rand_items += phase_items;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0)
      flag($sformatf("%0d expected results never arrived", verdict_q.size()));
    if (mismatches == 0)
      $display("layout_cache_blob_validator_top test passed");
    else
      $display("layout_cache_blob_validator_top test failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/lcbv_pkg.sv
rtl/lcbv_parse.sv
rtl/lcbv_verdict.sv
rtl/layout_cache_blob_validator_top.sv
test/tb_top.sv
